@@ design/ctok_pkg.sv @@
// Shared types, token kind codes and keyword table for the tokenizer.
`default_nettype none
package ctok_pkg;

  localparam int KIND_W = 5;

  localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
  localparam logic [KIND_W-1:0] K_LPAREN  = 5'd1;
  localparam logic [KIND_W-1:0] K_RPAREN  = 5'd2;
  localparam logic [KIND_W-1:0] K_LBRACK  = 5'd3;
  localparam logic [KIND_W-1:0] K_RBRACK  = 5'd4;
  localparam logic [KIND_W-1:0] K_LBRACE  = 5'd5;
  localparam logic [KIND_W-1:0] K_RBRACE  = 5'd6;
  localparam logic [KIND_W-1:0] K_SEMI    = 5'd7;
  localparam logic [KIND_W-1:0] K_PLUS    = 5'd8;
  localparam logic [KIND_W-1:0] K_MINUS   = 5'd9;
  localparam logic [KIND_W-1:0] K_STAR    = 5'd10;
  localparam logic [KIND_W-1:0] K_DIV     = 5'd11;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd12;
  localparam logic [KIND_W-1:0] K_LESS    = 5'd13;
  localparam logic [KIND_W-1:0] K_BANG    = 5'd14;
  localparam logic [KIND_W-1:0] K_STRING  = 5'd15;
  localparam logic [KIND_W-1:0] K_IDENT   = 5'd16;
  localparam logic [KIND_W-1:0] K_IF      = 5'd17;
  localparam logic [KIND_W-1:0] K_WHILE   = 5'd18;
  localparam logic [KIND_W-1:0] K_FOR     = 5'd19;
  localparam logic [KIND_W-1:0] K_RETURN  = 5'd20;
  localparam logic [KIND_W-1:0] K_BOOL    = 5'd21;
  localparam logic [KIND_W-1:0] K_INT     = 5'd22;
  localparam logic [KIND_W-1:0] K_DEC     = 5'd23;
  localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd24;

  localparam int NUM_KW = 6;
  localparam int KW_MAX = 6;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"t", "r", "u", "e", 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd2, 3'd5, 3'd3, 3'd6, 3'd4, 3'd5};
  localparam logic [KIND_W-1:0] KW_KIND [NUM_KW] = '{K_IF, K_WHILE, K_FOR, K_RETURN,
                                                     K_BOOL, K_BOOL};

  localparam int INQ_DEPTH  = 4;
  localparam int INQ_AW     = 2;
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = 2;

  typedef struct packed {
    logic [7:0]        ch;
    logic              is_zero;
    logic              is_blank;
    logic              is_eol;
    logic              is_alpha;
    logic              is_digit;
    logic              is_under;
    logic              is_slash;
    logic              is_star;
    logic              is_quote;
    logic              is_dot;
    logic [KIND_W-1:0] punct;
  } cls_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [31:0]       start;
    logic [15:0]       len;
    logic [31:0]       val;
    logic              last;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t t0;
    tok_t t1;
  } tokpush_t;

endpackage
`default_nettype wire

@@ design/c_like_source_tokenizer_core.sv @@
// Top level of the streaming source tokenizer.
// Takes one source byte per beat and returns tokens (kind, offset, length, integer value,
// last-of-run flag). A byte is taken every cycle while the four-entry byte queue has space;
// the lexer retires one byte per cycle while the four-entry token buffer holds at most two
// tokens, so with out_ready held the sustained rate is one byte per cycle and one token beat
// per cycle, with a byte that closes one token and forms another giving two beats in a row.
// An accepted byte is registered in the byte queue before the lexer retires it, and its
// tokens are registered in the token buffer before they can be taken. Blanks, line ends
// and comments give no beats; a NUL byte flushes any pending token, gives an end-of-input
// token and restarts offsets at zero.
`default_nettype none
module c_like_source_tokenizer_core #(
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_kind,
  output logic [31:0]      out_start_offset,
  output logic [15:0]      out_text_length,
  output logic [31:0]      out_int_value,
  output logic             out_last_of_run
);

  logic               q_pop, q_valid, ob_room;
  ctok_pkg::cls_t     q_data;
  ctok_pkg::tokpush_t push;
  ctok_pkg::tok_t     out_tok;

  ctok_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .q_pop    (q_pop),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  ctok_lexer #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .ob_room (ob_room),
    .push    (push)
  );

  ctok_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (ob_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (out_tok)
  );

  assign out_kind         = out_tok.kind;
  assign out_start_offset = out_tok.start;
  assign out_text_length  = out_tok.len;
  assign out_int_value    = out_tok.val;
  assign out_last_of_run  = out_tok.last;

endmodule
`default_nettype wire

@@ design/ctok_front.sv @@
// Front end: byte intake, character classification and the classified-byte queue.
`default_nettype none
module ctok_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_ch,
  input  wire logic          q_pop,
  output logic               q_valid,
  output ctok_pkg::cls_t     q_data
);

  ctok_pkg::cls_t                  cls;
  ctok_pkg::cls_t                  q_mem [ctok_pkg::INQ_DEPTH];
  logic [ctok_pkg::INQ_AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ctok_pkg::INQ_AW:0]       cnt_r, cnt_nxt;
  logic                            push;

  always_comb begin
    cls           = '0;
    cls.ch        = in_ch;
    cls.is_zero   = (in_ch == 8'h00);
    cls.is_blank  = (in_ch == 8'd32) || (in_ch == 8'd9) || (in_ch == 8'd12) ||
                    (in_ch == 8'd11) || (in_ch == 8'd10) || (in_ch == 8'd13);
    cls.is_eol    = (in_ch == 8'd10) || (in_ch == 8'd13);
    cls.is_alpha  = ((in_ch >= "a") && (in_ch <= "z")) || ((in_ch >= "A") && (in_ch <= "Z"));
    cls.is_digit  = (in_ch >= "0") && (in_ch <= "9");
    cls.is_under  = (in_ch == "_");
    cls.is_slash  = (in_ch == "/");
    cls.is_star   = (in_ch == "*");
    cls.is_quote  = (in_ch == "\"");
    cls.is_dot    = (in_ch == ".");
    case (in_ch)
      "(":     cls.punct = ctok_pkg::K_LPAREN;
      ")":     cls.punct = ctok_pkg::K_RPAREN;
      "[":     cls.punct = ctok_pkg::K_LBRACK;
      "]":     cls.punct = ctok_pkg::K_RBRACK;
      "{":     cls.punct = ctok_pkg::K_LBRACE;
      "}":     cls.punct = ctok_pkg::K_RBRACE;
      ";":     cls.punct = ctok_pkg::K_SEMI;
      "+":     cls.punct = ctok_pkg::K_PLUS;
      "-":     cls.punct = ctok_pkg::K_MINUS;
      "*":     cls.punct = ctok_pkg::K_STAR;
      "/":     cls.punct = ctok_pkg::K_DIV;
      "=":     cls.punct = ctok_pkg::K_ASSIGN;
      "<":     cls.punct = ctok_pkg::K_LESS;
      "!":     cls.punct = ctok_pkg::K_BANG;
      default: cls.punct = ctok_pkg::K_EOF;
    endcase
  end

  assign in_ready = (cnt_r != (ctok_pkg::INQ_AW+1)'(ctok_pkg::INQ_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = q_mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + {{ctok_pkg::INQ_AW{1'b0}}, push} - {{ctok_pkg::INQ_AW{1'b0}}, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= cls;
    end
  end

endmodule
`default_nettype wire

@@ design/ctok_lexer.sv @@
// Back end: lexer state machine, one classified byte per cycle while the token buffer has room, up to two tokens out.
`default_nettype none
module ctok_lexer #(
  parameter int KEYWORD_CHARS = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire ctok_pkg::cls_t  q_data,
  output logic                 q_pop,
  input  wire logic            ob_room,
  output ctok_pkg::tokpush_t   push
);

  localparam int KP_AW = $clog2(KEYWORD_CHARS);

  typedef enum logic [7:0] {
    M_IDLE   = 8'b0000_0001,
    M_SLASH  = 8'b0000_0010,
    M_LINE   = 8'b0000_0100,
    M_BLOCK  = 8'b0000_1000,
    M_STRING = 8'b0001_0000,
    M_IDENT  = 8'b0010_0000,
    M_NUM    = 8'b0100_0000,
    M_NUMDOT = 8'b1000_0000
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic [15:0] tlen_r, tlen_nxt, tlen_inc;
  logic [31:0] nval_r, nval_nxt, nval_acc;
  logic [35:0] nval_x10;
  logic [1:0]  dots_r, dots_nxt;
  logic [7:0]  kp_r [KEYWORD_CHARS];
  logic        kp_we;
  logic [KP_AW-1:0] kp_wa;

  ctok_pkg::cls_t c;
  logic           fire;
  logic           pend_v, idle_v, run_idle, same;
  ctok_pkg::tok_t pend_t, idle_t, num_t;
  logic [ctok_pkg::KIND_W-1:0] id_kind;

  assign c     = q_data;
  assign fire  = q_valid && ob_room;
  assign q_pop = fire;

  assign tlen_inc = (tlen_r == 16'hFFFF) ? tlen_r : tlen_r + 16'd1;
  assign nval_x10 = {1'b0, nval_r, 3'b000} + {3'b000, nval_r, 1'b0} + {32'd0, c.ch[3:0]};
  assign nval_acc = (nval_x10[35:32] != 4'd0) ? 32'hFFFF_FFFF : nval_x10[31:0];

  always_comb begin
    id_kind = ctok_pkg::K_IDENT;
    same    = 1'b0;
    for (int k = ctok_pkg::NUM_KW - 1; k >= 0; k--) begin
      same = (tlen_r == {13'd0, ctok_pkg::KW_LEN[k]});
      for (int i = 0; i < ctok_pkg::KW_MAX; i++) begin
        if ((i < int'(ctok_pkg::KW_LEN[k])) && (i < KEYWORD_CHARS)) begin
          if (kp_r[KP_AW'(i)] != ctok_pkg::KW_TEXT[k][i]) begin
            same = 1'b0;
          end
        end
      end
      if (same) begin
        id_kind = ctok_pkg::KW_KIND[k];
      end
    end
  end

  always_comb begin
    num_t       = '0;
    num_t.start = tstart_r;
    num_t.len   = tlen_r;
    case (dots_r)
      2'd0: begin
        num_t.kind = ctok_pkg::K_INT;
        num_t.val  = nval_r;
      end
      2'd1: begin
        num_t.kind = ctok_pkg::K_DEC;
        num_t.val  = nval_r;
      end
      default: num_t.kind = ctok_pkg::K_UNKNOWN;
    endcase
  end

  always_comb begin
    idle_t       = '0;
    idle_t.start = pos_r;
    idle_v       = 1'b0;
    if (c.is_zero) begin
      idle_v      = 1'b1;
      idle_t.kind = ctok_pkg::K_EOF;
    end else if (c.is_blank || c.is_slash || c.is_quote || c.is_alpha || c.is_digit) begin
      idle_v = 1'b0;
    end else if (c.punct != ctok_pkg::K_EOF) begin
      idle_v      = 1'b1;
      idle_t.kind = c.punct;
      idle_t.len  = 16'd1;
    end else begin
      idle_v      = 1'b1;
      idle_t.kind = ctok_pkg::K_UNKNOWN;
      idle_t.len  = 16'd1;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    nval_nxt   = nval_r;
    dots_nxt   = dots_r;
    kp_we      = 1'b0;
    kp_wa      = tlen_r[KP_AW-1:0];
    pend_v     = 1'b0;
    pend_t     = '0;
    run_idle   = 1'b0;
    case (mode_r)
      M_SLASH: begin
        if (c.is_slash) begin
          mode_nxt = M_LINE;
        end else if (c.is_star) begin
          mode_nxt = M_BLOCK;
          dots_nxt = 2'd0;
        end else begin
          pend_v       = 1'b1;
          pend_t.kind  = ctok_pkg::K_DIV;
          pend_t.start = tstart_r;
          pend_t.len   = 16'd1;
          run_idle     = 1'b1;
        end
      end
      M_LINE: begin
        if (c.is_zero) begin
          run_idle = 1'b1;
        end else if (c.is_eol) begin
          mode_nxt = M_IDLE;
        end
      end
      M_BLOCK: begin
        if (c.is_zero) begin
          run_idle = 1'b1;
        end else if ((dots_r != 2'd0) && c.is_slash) begin
          mode_nxt = M_IDLE;
        end else begin
          dots_nxt = c.is_star ? 2'd1 : 2'd0;
        end
      end
      M_STRING: begin
        if (c.is_quote) begin
          pend_v       = 1'b1;
          pend_t.kind  = ctok_pkg::K_STRING;
          pend_t.start = tstart_r;
          pend_t.len   = tlen_r;
          mode_nxt     = M_IDLE;
        end else if (c.is_zero) begin
          pend_v       = 1'b1;
          pend_t.kind  = ctok_pkg::K_UNKNOWN;
          pend_t.start = tstart_r;
          pend_t.len   = tlen_r;
          run_idle     = 1'b1;
        end else begin
          tlen_nxt = tlen_inc;
        end
      end
      M_IDENT: begin
        if (c.is_alpha || c.is_digit || c.is_under) begin
          kp_we    = (tlen_r < 16'(KEYWORD_CHARS));
          tlen_nxt = tlen_inc;
        end else begin
          pend_v       = 1'b1;
          pend_t.kind  = id_kind;
          pend_t.start = tstart_r;
          pend_t.len   = tlen_r;
          run_idle     = 1'b1;
        end
      end
      M_NUM: begin
        if (c.is_digit) begin
          if (dots_r == 2'd0) begin
            nval_nxt = nval_acc;
          end
          tlen_nxt = tlen_inc;
        end else if (c.is_dot) begin
          if (dots_r != 2'd3) begin
            dots_nxt = dots_r + 2'd1;
          end
          tlen_nxt = tlen_inc;
          mode_nxt = M_NUMDOT;
        end else begin
          pend_v   = 1'b1;
          pend_t   = num_t;
          run_idle = 1'b1;
        end
      end
      M_NUMDOT: begin
        if (c.is_digit) begin
          tlen_nxt = tlen_inc;
          mode_nxt = M_NUM;
        end else begin
          pend_v   = 1'b1;
          pend_t   = num_t;
          run_idle = 1'b1;
        end
      end
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      mode_nxt = M_IDLE;
      if (c.is_zero || c.is_blank) begin
        mode_nxt = M_IDLE;
      end else if (c.is_slash) begin
        mode_nxt   = M_SLASH;
        tstart_nxt = pos_r;
      end else if (c.is_quote) begin
        mode_nxt   = M_STRING;
        tstart_nxt = pos_r + 32'd1;
        tlen_nxt   = 16'd0;
      end else if (c.is_alpha) begin
        mode_nxt   = M_IDENT;
        tstart_nxt = pos_r;
        tlen_nxt   = 16'd1;
        kp_we      = 1'b1;
        kp_wa      = '0;
      end else if (c.is_digit) begin
        mode_nxt   = M_NUM;
        tstart_nxt = pos_r;
        tlen_nxt   = 16'd1;
        nval_nxt   = {28'd0, c.ch[3:0]};
        dots_nxt   = 2'd0;
      end
    end

    pos_nxt = c.is_zero ? 32'd0 : pos_r + 32'd1;
  end

  always_comb begin
    push    = '0;
    if (pend_v && run_idle && idle_v) begin
      push.v0      = fire;
      push.v1      = fire;
      push.t0      = pend_t;
      push.t1      = idle_t;
      push.t1.last = 1'b1;
    end else if (pend_v) begin
      push.v0      = fire;
      push.t0      = pend_t;
      push.t0.last = 1'b1;
    end else if (run_idle && idle_v) begin
      push.v0      = fire;
      push.t0      = idle_t;
      push.t0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      nval_r   <= '0;
      dots_r   <= '0;
    end else if (fire) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      nval_r   <= nval_nxt;
      dots_r   <= dots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && kp_we) begin
      kp_r[kp_wa] <= c.ch;
    end
  end

endmodule
`default_nettype wire

@@ design/ctok_outbuf.sv @@
// Token buffer: takes up to two tokens a cycle, hands out one beat a cycle while out_ready is high.
`default_nettype none
module ctok_outbuf (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ctok_pkg::tokpush_t  push,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ctok_pkg::tok_t           out_tok
);

  ctok_pkg::tok_t                 buf_r [ctok_pkg::OUTQ_DEPTH];
  logic [ctok_pkg::OUTQ_AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt, wp1;
  logic [ctok_pkg::OUTQ_AW:0]     cnt_r, cnt_nxt;
  logic                           pop;
  logic [1:0]                     nput;

  assign out_valid = (cnt_r != '0);
  assign out_tok   = buf_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign room      = (cnt_r <= (ctok_pkg::OUTQ_AW+1)'(ctok_pkg::OUTQ_DEPTH - 2));
  assign wp1       = wp_r + 1'b1;
  assign nput      = {1'b0, push.v0} + {1'b0, push.v1};

  always_comb begin
    wp_nxt  = wp_r + ctok_pkg::OUTQ_AW'(nput);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (ctok_pkg::OUTQ_AW+1)'(nput) - {{ctok_pkg::OUTQ_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      buf_r[wp_r] <= push.t0;
    end
    if (push.v1) begin
      buf_r[wp1] <= push.t1;
    end
  end

endmodule
`default_nettype wire
